### rtl/csf_pkg.sv
package csf_pkg;

    localparam int COORD_BITS = 20;
    localparam int MAX_POINTS = 32768;
    localparam int CNT_BITS   = 16;
    localparam int SUM_BITS   = COORD_BITS + CNT_BITS;
    localparam int EXT_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * EXT_BITS + 1;
    localparam int DIV_STEPS  = SUM_BITS;
    localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] CFG_MAX_ALTITUDE = 3'd0;
    localparam logic [2:0] CFG_MIN_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_MAX_HEIGHT   = 3'd2;
    localparam logic [2:0] CFG_MAX_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_MIN_POINTS   = 3'd4;
    localparam logic [2:0] CFG_MAX_POINTS   = 3'd5;

    localparam logic [3:0] RING_FIRST = 4'd0;
    localparam logic [3:0] RING_LAST  = 4'd15;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic [3:0]                   ring;
        logic                         near_track;
        logic                         last_point;
    } t_in_word;

    typedef struct packed {
        logic                         accepted;
        logic                         class_a;
        logic signed [COORD_BITS-1:0] centroid_x;
        logic signed [COORD_BITS-1:0] centroid_y;
        logic signed [COORD_BITS-1:0] centroid_z;
        logic [COORD_BITS-1:0]        extent_x;
        logic [COORD_BITS-1:0]        extent_y;
        logic [COORD_BITS-1:0]        extent_z;
        logic [CNT_BITS-1:0]          point_count;
    } t_out_word;

    typedef struct packed {
        logic signed [19:0] max_altitude;
        logic [19:0]        min_height;
        logic [19:0]        max_height;
        logic [19:0]        max_width;
        logic [15:0]        min_points;
        logic [15:0]        max_points;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV_START,
        ST_DIVIDE,
        ST_SQUARE,
        ST_DECIDE,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic accum;
        logic div_start;
        logic div_step;
        logic square;
        logic decide;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

### rtl/csf_ctrl.sv
module csf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  logic           i_out_stall,
    input  csf_pkg::t_status i_status,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output csf_pkg::t_cmd  o_cmd
);
    import csf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accum = 1'b1;
                    if (i_in_last) n_state = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.clear = 1'b1;
                    n_state = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

endmodule

### rtl/csf_datapath.sv
module csf_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csf_pkg::t_in_word i_in,
    input  csf_pkg::t_cfg     i_cfg,
    input  csf_pkg::t_cmd     i_cmd,
    output csf_pkg::t_status  o_status,
    output csf_pkg::t_out_word o_out
);
    import csf_pkg::*;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [CNT_BITS:0] CNT_SAT = (CNT_BITS+1)'(MAX_POINTS);

    logic signed [SUM_BITS-1:0]   r_sum [3];
    logic signed [COORD_BITS-1:0] r_min [3];
    logic signed [COORD_BITS-1:0] r_max [3];
    logic [CNT_BITS:0]            r_count;
    logic                         r_edge;
    logic                         r_near;

    // divider: restoring, one quotient bit per cycle, all three axes in parallel
    logic [SUM_BITS-1:0]  r_quo [3];
    logic [CNT_BITS:0]    r_rem [3];
    logic                 r_neg [3];
    logic [STEP_BITS-1:0] r_step;

    logic [SQ_BITS-1:0] r_wsq, r_w2;
    logic [SQ_BITS-1:0] r_exsq, r_eysq;
    logic               r_accepted, r_class_a;

    logic signed [COORD_BITS-1:0] w_p [3];
    logic [EXT_BITS-1:0]          w_ext [3];

    assign w_p[0] = i_in.point_x;
    assign w_p[1] = i_in.point_y;
    assign w_p[2] = i_in.point_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_ext[a] = EXT_BITS'($signed({r_max[a][COORD_BITS-1], r_max[a]})
                     - $signed({r_min[a][COORD_BITS-1], r_min[a]}));
        end
    end

    // squared horizontal diagonal and limits
    logic [SQ_BITS:0]   w_dsq;
    logic               w_fail, w_loose, w_cnt_ok;
    logic [CNT_BITS:0]  w_min_pts, w_max_pts;
    logic [EXT_BITS-1:0] w_ez;

    always_comb begin
        w_dsq     = {1'b0, r_exsq} + {1'b0, r_eysq};
        w_ez      = w_ext[2];
        w_fail    = (r_min[2] > i_cfg.max_altitude)
                 || (w_ez < {1'b0, i_cfg.min_height} && !r_edge)
                 || (w_ez > {1'b0, i_cfg.max_height})
                 || (w_dsq > {1'b0, r_wsq});
        w_loose   = (w_dsq < {1'b0, r_w2}) || (w_ez < {1'b0, i_cfg.max_height});
        w_min_pts = {1'b0, i_cfg.min_points};
        w_max_pts = {1'b0, i_cfg.max_points};
        w_cnt_ok  = !(r_count < w_min_pts) && !(r_count > w_max_pts);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
                r_min[a] <= COORD_MAX;
                r_max[a] <= COORD_MIN;
            end
            r_count <= '0;
            r_edge  <= 1'b0;
        end else if (i_cmd.accum) begin
            for (int a = 0; a < 3; a++) begin
                if (w_p[a] < r_min[a]) r_min[a] <= w_p[a];
                if (w_p[a] > r_max[a]) r_max[a] <= w_p[a];
                if (r_count < CNT_SAT)
                    r_sum[a] <= r_sum[a] + SUM_BITS'(w_p[a]);
            end
            if (r_count < CNT_SAT) r_count <= r_count + 1'b1;
            if (i_in.ring == RING_FIRST || i_in.ring == RING_LAST) r_edge <= 1'b1;
            r_near <= i_in.near_track;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.div_start) begin
            r_step <= STEP_BITS'(DIV_STEPS);
        end else if (i_cmd.div_step && r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [CNT_BITS+1:0] trial;
        if (i_cmd.div_start) begin
            for (int a = 0; a < 3; a++) begin
                r_neg[a] <= r_sum[a][SUM_BITS-1];
                r_quo[a] <= r_sum[a][SUM_BITS-1] ? SUM_BITS'(-r_sum[a])
                                                 : SUM_BITS'(r_sum[a]);
                r_rem[a] <= '0;
            end
        end else if (i_cmd.div_step && r_step != '0) begin
            for (int a = 0; a < 3; a++) begin
                trial = {r_rem[a], r_quo[a][SUM_BITS-1]} - {1'b0, r_count};
                if (!trial[CNT_BITS+1]) begin
                    r_rem[a] <= trial[CNT_BITS:0];
                    r_quo[a] <= {r_quo[a][SUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem[a] <= {r_rem[a][CNT_BITS-1:0], r_quo[a][SUM_BITS-1]};
                    r_quo[a] <= {r_quo[a][SUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // widen the operands first so the products keep every bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_wsq <= SQ_BITS'({20'd0, i_cfg.max_width} * {20'd0, i_cfg.max_width});
        end
        if (i_cmd.square) begin
            r_exsq <= SQ_BITS'({{EXT_BITS{1'b0}}, w_ext[0]} * {{EXT_BITS{1'b0}}, w_ext[0]});
            r_eysq <= SQ_BITS'({{EXT_BITS{1'b0}}, w_ext[1]} * {{EXT_BITS{1'b0}}, w_ext[1]});
            r_w2   <= {r_wsq[SQ_BITS-3:0], 2'b00};
        end
        if (i_cmd.decide) begin
            r_accepted <= (!w_fail || (r_near && w_loose)) && w_cnt_ok;
            r_class_a  <= !w_fail && w_cnt_ok;
        end
    end

    assign o_status.div_done  = (r_step == STEP_BITS'(1));

    always_comb begin
        logic [SUM_BITS-1:0] q [3];
        for (int a = 0; a < 3; a++) q[a] = r_neg[a] ? -r_quo[a] : r_quo[a];
        o_out.accepted    = r_accepted;
        o_out.class_a     = r_class_a;
        o_out.centroid_x  = q[0][COORD_BITS-1:0];
        o_out.centroid_y  = q[1][COORD_BITS-1:0];
        o_out.centroid_z  = q[2][COORD_BITS-1:0];
        o_out.extent_x    = w_ext[0][COORD_BITS-1:0];
        o_out.extent_y    = w_ext[1][COORD_BITS-1:0];
        o_out.extent_z    = w_ext[2][COORD_BITS-1:0];
        o_out.point_count = r_count[CNT_BITS] ? {CNT_BITS{1'b1}} : r_count[CNT_BITS-1:0];
    end

endmodule

### rtl/cluster_stats_shape_filter.sv
// Cluster statistics and shape filter.
// Input channel: one word per point (x, y, z, ring, near_track, last_point),
// taken when i_in_valid is high and o_in_stall low. Points of a cluster are
// taken one per cycle; near_track is read with the last point.
// Output channel: one word per cluster (accept, class A, centroid, extents,
// count), delivered when o_out_valid is high and i_out_stall low.
// After the edge that takes the last point, the block loads the divider,
// runs 36 restoring steps forming the centroid one quotient bit a cycle,
// squares the extents and evaluates the rules; then o_out_valid rises.
// One point per cycle while accumulating; the input is stalled from the
// last point until the result word is taken, so no point of the next
// cluster enters before the result has left.
// A stalled result holds its word; the cluster state clears when it leaves.
// Configuration: write port i_cfg_valid/o_cfg_ready with index and data,
// always ready; write only while idle. Reset (synchronous, active low)
// restores the register defaults and clears the cluster state.
module cluster_stats_shape_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  csf_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output csf_pkg::t_out_word o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);
    import csf_pkg::*;

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    // register file: ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_altitude <= 20'sd2000;
            r_cfg.min_height   <= 20'd500;
            r_cfg.max_height   <= 20'd1800;
            r_cfg.max_width    <= 20'd2000;
            r_cfg.min_points   <= 16'd4;
            r_cfg.max_points   <= 16'd25000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_ALTITUDE: r_cfg.max_altitude <= i_cfg_data;
                CFG_MIN_HEIGHT:   r_cfg.min_height   <= i_cfg_data;
                CFG_MAX_HEIGHT:   r_cfg.max_height   <= i_cfg_data;
                CFG_MAX_WIDTH:    r_cfg.max_width    <= i_cfg_data;
                CFG_MIN_POINTS:   r_cfg.min_points   <= i_cfg_data[15:0];
                CFG_MAX_POINTS:   r_cfg.max_points   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    csf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_point),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    csf_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in_data),
        .i_cfg    (r_cfg),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_out    (o_out_data)
    );

endmodule

### sim/cluster_stats_shape_filter_checker.sv
`timescale 1ns / 100ps

module cluster_stats_shape_filter_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  csf_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  csf_pkg::t_out_word i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_clusters_seen
);
    import csf_pkg::*;

    localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO = -(64'sd1 <<< (COORD_BITS - 1));

    t_cfg cfg;
    longint sx, sy, sz;
    longint bmin [3];
    longint bmax [3];
    int unsigned npts;
    bit periph;
    t_out_word cluster_results [$];

    function automatic bit sq_gt(longint unsigned a, longint unsigned b, longint unsigned lim);
        return (a * a + b * b) > lim;
    endfunction

    task automatic clear_cluster();
        sx = 0; sy = 0; sz = 0;
        for (int i = 0; i < 3; i++) begin
            bmin[i] = COORD_HI;
            bmax[i] = COORD_LO;
        end
        npts = 0;
        periph = 0;
    endtask

    task automatic fold_point(t_in_word w);
        longint p [3];
        longint unsigned ex, ey, ez, w2;
        bit fail, acc, cls;
        t_out_word r;
        p[0] = longint'(w.point_x);
        p[1] = longint'(w.point_y);
        p[2] = longint'(w.point_z);
        if (w.ring == RING_FIRST || w.ring == RING_LAST) periph = 1;
        for (int i = 0; i < 3; i++) begin
            if (p[i] < bmin[i]) bmin[i] = p[i];
            if (p[i] > bmax[i]) bmax[i] = p[i];
        end
        if (npts < MAX_POINTS) begin
            sx += p[0]; sy += p[1]; sz += p[2];
            npts++;
        end
        if (!w.last_point) return;
        ex = bmax[0] - bmin[0];
        ey = bmax[1] - bmin[1];
        ez = bmax[2] - bmin[2];
        w2 = longint'(cfg.max_width) * longint'(cfg.max_width);
        fail = 0;
        if (bmin[2] > longint'(cfg.max_altitude)) fail = 1;
        if (ez < cfg.min_height && !periph) fail = 1;
        if (ez > cfg.max_height) fail = 1;
        if (sq_gt(ex, ey, w2)) fail = 1;
        cls = !fail;
        if (fail && w.near_track) begin
            if ((ex * ex + ey * ey) < 4 * w2) fail = 0;
            if (ez < cfg.max_height) fail = 0;
            cls = 0;
        end
        acc = !fail;
        if (npts < cfg.min_points || npts > cfg.max_points) acc = 0;
        if (!acc) cls = 0;
        r.accepted    = acc;
        r.class_a     = cls;
        r.centroid_x  = COORD_BITS'(sx / longint'(npts));
        r.centroid_y  = COORD_BITS'(sy / longint'(npts));
        r.centroid_z  = COORD_BITS'(sz / longint'(npts));
        r.extent_x    = COORD_BITS'(ex);
        r.extent_y    = COORD_BITS'(ey);
        r.extent_z    = COORD_BITS'(ez);
        r.point_count = (npts > 65535) ? 16'hffff : CNT_BITS'(npts);
        cluster_results = {cluster_results, r};
        clear_cluster();
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            cfg <= '{max_altitude: 20'sd2000, min_height: 20'd500, max_height: 20'd1800,
                     max_width: 20'd2000, min_points: 16'd4, max_points: 16'd25000};
            clear_cluster();
            cluster_results.delete();
            o_fail_count <= 0;
            o_clusters_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_ALTITUDE: cfg.max_altitude <= i_cfg_data;
                    CFG_MIN_HEIGHT:   cfg.min_height   <= i_cfg_data;
                    CFG_MAX_HEIGHT:   cfg.max_height   <= i_cfg_data;
                    CFG_MAX_WIDTH:    cfg.max_width    <= i_cfg_data;
                    CFG_MIN_POINTS:   cfg.min_points   <= i_cfg_data[15:0];
                    CFG_MAX_POINTS:   cfg.max_points   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) fold_point(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                o_clusters_seen <= o_clusters_seen + 1;
                if (cluster_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cluster_results.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= cluster_results.size();
        end
    end
endmodule

### sim/cluster_stats_shape_filter_tb.sv
`timescale 1ns / 100ps

module cluster_stats_shape_filter_tb;
    import csf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    t_out_word o_out_data;
    logic      i_cfg_valid = 0;
    logic      o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;

    int fail_count, pending, clusters_seen;
    int idle_cycles = 0;
    bit calm = 0;         // long stretch with no idling on either side
    int points_sent = 0;

    cluster_stats_shape_filter uut (.*);

    cluster_stats_shape_filter_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_clusters_seen(clusters_seen)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Randomly stall the result side, except during the calm stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 12);
    end

    // Watchdog: count cycles with no word moving on the input or output channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Send one point word and hold it until taken. Valid stays high so the
    // next word can follow directly; an idle cycle or settle drops it.
    task automatic send_point(t_in_word w);
        while (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        points_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // Drop valid, let every expected result arrive, then idle a while.
    task automatic settle();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [19:0] rand_coord(int spread);
        int v;
        case ($urandom_range(9))
            0: return 20'h7ffff;
            1: return 20'h80000;
            2: return 20'($urandom);
            default: begin
                v = $urandom_range(2 * spread) - spread;
                return 20'(v);
            end
        endcase
    endfunction

    // Send one cluster of n points around a random center, or with random coordinates when wild is set.
    task automatic send_cluster(int n, int spread, bit wild);
        t_in_word w;
        int cx, cy, cz;
        cx = $urandom_range(8000) - 4000;
        cy = $urandom_range(8000) - 4000;
        cz = $urandom_range(3000) - 500;
        for (int i = 0; i < n; i++) begin
            if (wild) begin
                w.point_x = rand_coord(spread);
                w.point_y = rand_coord(spread);
                w.point_z = rand_coord(spread);
            end else begin
                w.point_x = 20'(cx + int'($urandom_range(2 * spread)) - spread);
                w.point_y = 20'(cy + int'($urandom_range(2 * spread)) - spread);
                w.point_z = 20'(cz + int'($urandom_range(2 * spread)) - spread);
            end
            w.ring       = 4'($urandom);
            w.near_track = $urandom_range(1);
            w.last_point = (i == n - 1);
            send_point(w);
        end
    endtask

    task automatic send_fixed(int x, int y, int z, logic [3:0] ring, bit near, bit last);
        t_in_word w;
        w.point_x = 20'(x); w.point_y = 20'(y); w.point_z = 20'(z);
        w.ring = ring; w.near_track = near; w.last_point = last;
        send_point(w);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: a lone point, extreme corners, peripheral rings,
        // near-track rescue, too few points.
        send_fixed(0, 0, 0, 4'd5, 0, 1);
        send_fixed(524287, 524287, 524287, RING_FIRST, 0, 0);
        send_fixed(-524288, -524288, -524288, 4'd3, 1, 1);
        for (int i = 0; i < 5; i++) send_fixed(100 * i, 50, 1000 + 10 * i, RING_LAST, 0, i == 4);
        for (int i = 0; i < 5; i++) send_fixed(600 * i, 0, 300 * i, 4'd7, 1, i == 4);
        for (int i = 0; i < 4; i++) send_fixed(-10 * i, -20, -400 * i, 4'd8, 0, i == 3);
        send_fixed(5, 5, 5, 4'd9, 1, 0);
        send_fixed(1000, -3000, 1500, 4'd2, 0, 1);
        settle();

        // Extreme settings, including zero max_points and bounds beyond range.
        write_reg(CFG_MAX_ALTITUDE, 20'h80000);
        write_reg(CFG_MIN_HEIGHT, 20'hfffff);
        write_reg(CFG_MAX_HEIGHT, 20'd0);
        write_reg(CFG_MAX_WIDTH, 20'd0);
        write_reg(CFG_MIN_POINTS, 20'd1);
        write_reg(CFG_MAX_POINTS, 20'd0);
        write_reg(3'd7, 20'hfffff);
        for (int c = 0; c < 6; c++) send_cluster($urandom_range(1, 6), 300, c[0]);
        settle();

        write_reg(CFG_MAX_ALTITUDE, 20'h7ffff);
        write_reg(CFG_MIN_HEIGHT, 20'd0);
        write_reg(CFG_MAX_HEIGHT, 20'hfffff);
        write_reg(CFG_MAX_WIDTH, 20'hfffff);
        write_reg(CFG_MIN_POINTS, 20'hffff);
        write_reg(CFG_MAX_POINTS, 20'hffff);
        for (int c = 0; c < 6; c++) send_cluster($urandom_range(1, 6), 300, c[0]);
        settle();

        // Random phases: mostly plausible clusters, some wild coordinates.
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(CFG_MAX_ALTITUDE, 20'($urandom_range(4000) - 1000));
            write_reg(CFG_MIN_HEIGHT, 20'($urandom_range(1500)));
            write_reg(CFG_MAX_HEIGHT, 20'($urandom_range(500, 3000)));
            write_reg(CFG_MAX_WIDTH, 20'($urandom_range(200, 3000)));
            write_reg(CFG_MIN_POINTS, 20'($urandom_range(1, 6)));
            write_reg(CFG_MAX_POINTS, 20'($urandom_range(3, 14)));
            calm = (phase == 3);
            for (int c = 0; c < 32; c++)
                send_cluster($urandom_range(1, 14), $urandom_range(10, 1500),
                             $urandom_range(9) == 0);
            calm = 0;
            settle();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d points in %0d clusters over nine register settings",
                 points_sent, clusters_seen);
        $display("with random stalls on both channels and one stall-free stretch");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
